### design/ttf_pkg.sv
package ttf_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } corner_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic signed [15:0] binormal_x;
        logic signed [15:0] binormal_y;
        logic signed [15:0] binormal_z;
        logic               normal_fell_back;
        logic               tangent_fell_back;
        logic               binormal_fell_back;
    } frame_t;

    // edges and texture deltas of one triangle
    typedef struct packed {
        logic signed [32:0] e1x;
        logic signed [32:0] e1y;
        logic signed [32:0] e1z;
        logic signed [32:0] e2x;
        logic signed [32:0] e2y;
        logic signed [32:0] e2z;
        logic signed [32:0] d1u;
        logic signed [32:0] d1v;
        logic signed [32:0] d2u;
        logic signed [32:0] d2v;
    } tri_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_ctl_t;

    localparam logic [62:0] MIN_LEN_SQ_RESET = 63'd1;

endpackage

### design/ttf_queue.sv
module ttf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  ttf_pkg::tri_t  wr_data,
    input  logic           push,
    input  logic           pop,
    output ttf_pkg::tri_t  rd_data,
    output logic           full,
    output logic           empty
);

    ttf_pkg::tri_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if ((push && !full) && !(pop && !empty))
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### design/ttf_front.sv
module ttf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              corner_valid,
    output logic              corner_stall,
    input  ttf_pkg::corner_t  corner,
    input  logic              q_full,
    output ttf_pkg::q_ctl_t   q_ctl,
    output ttf_pkg::tri_t     tri_data
);

    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    ttf_pkg::corner_t c0_reg;
    ttf_pkg::corner_t c1_reg;
    logic             accept;

    assign corner_stall = (count_reg == 2'd2) && q_full;
    assign accept       = corner_valid && !corner_stall;
    assign q_ctl.push   = accept && (count_reg == 2'd2);
    assign q_ctl.full   = q_full;

    always_comb
    begin
        tri_data.e1x = {c1_reg.pos_x[31], c1_reg.pos_x} - {c0_reg.pos_x[31], c0_reg.pos_x};
        tri_data.e1y = {c1_reg.pos_y[31], c1_reg.pos_y} - {c0_reg.pos_y[31], c0_reg.pos_y};
        tri_data.e1z = {c1_reg.pos_z[31], c1_reg.pos_z} - {c0_reg.pos_z[31], c0_reg.pos_z};
        tri_data.e2x = {corner.pos_x[31], corner.pos_x} - {c0_reg.pos_x[31], c0_reg.pos_x};
        tri_data.e2y = {corner.pos_y[31], corner.pos_y} - {c0_reg.pos_y[31], c0_reg.pos_y};
        tri_data.e2z = {corner.pos_z[31], corner.pos_z} - {c0_reg.pos_z[31], c0_reg.pos_z};
        tri_data.d1u = {c1_reg.tex_u[31], c1_reg.tex_u} - {c0_reg.tex_u[31], c0_reg.tex_u};
        tri_data.d1v = {c1_reg.tex_v[31], c1_reg.tex_v} - {c0_reg.tex_v[31], c0_reg.tex_v};
        tri_data.d2u = {corner.tex_u[31], corner.tex_u} - {c0_reg.tex_u[31], c0_reg.tex_u};
        tri_data.d2v = {corner.tex_v[31], corner.tex_v} - {c0_reg.tex_v[31], c0_reg.tex_v};
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = (count_reg == 2'd2) ? 2'd0 : count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (count_reg == 2'd0))
        begin
            c0_reg <= corner;
        end
        if (accept && (count_reg == 2'd1))
        begin
            c1_reg <= corner;
        end
    end

endmodule

### design/ttf_back.sv
module ttf_back #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [62:0]      cfg_wdata,
    input  ttf_pkg::tri_t    q_data,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             frame_valid,
    input  logic             frame_stall,
    output ttf_pkg::frame_t  frame
);

    localparam int NUMW = OUT_FRAC_BITS + 32;
    localparam int QW   = OUT_FRAC_BITS + 1;
    localparam int DCW  = $clog2(NUMW);
    localparam logic [15:0] ONE = (OUT_FRAC_BITS >= 15) ? 16'd32767
                                                        : 16'(1 << OUT_FRAC_BITS);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_MUL    = 5'd1;
    localparam logic [4:0] S_ACC    = 5'd2;
    localparam logic [4:0] S_VINIT  = 5'd3;
    localparam logic [4:0] S_LOAD   = 5'd4;
    localparam logic [4:0] S_CLASS  = 5'd5;
    localparam logic [4:0] S_SQM    = 5'd6;
    localparam logic [4:0] S_SQA    = 5'd7;
    localparam logic [4:0] S_SQC    = 5'd8;
    localparam logic [4:0] S_NORM   = 5'd9;
    localparam logic [4:0] S_RSM    = 5'd10;
    localparam logic [4:0] S_RSA    = 5'd11;
    localparam logic [4:0] S_SQI    = 5'd12;
    localparam logic [4:0] S_SQRT   = 5'd13;
    localparam logic [4:0] S_DLOAD  = 5'd14;
    localparam logic [4:0] S_DIV    = 5'd15;
    localparam logic [4:0] S_DSTORE = 5'd16;
    localparam logic [4:0] S_WRITE  = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    logic [4:0]          state_reg;
    logic [62:0]         min_len_sq_reg;
    ttf_pkg::tri_t       tri_reg;
    logic [4:0]          k_reg;
    logic signed [65:0]  p_reg;
    logic signed [66:0]  acc_reg;
    logic signed [66:0]  res_reg [10];
    logic [1:0]          v_reg;
    logic [1:0]          c_reg;
    logic [65:0]         mag_reg [3];
    logic                neg_reg [3];
    logic [65:0]         or_reg;
    logic [65:0]         sq_reg;
    logic [63:0]         l2_reg;
    logic [63:0]         x_reg;
    logic [63:0]         root_reg;
    logic [63:0]         bit_reg;
    logic [4:0]          it_reg;
    logic [NUMW-1:0]     num_reg;
    logic [31:0]         rem_reg;
    logic [QW-1:0]       q_reg;
    logic [DCW-1:0]      dcnt_reg;
    logic                deg_reg;
    logic [15:0]         comp_reg [9];
    logic                fb_reg [3];
    logic                out_valid_reg;
    ttf_pkg::frame_t     out_reg;

    logic signed [32:0]  op_a;
    logic signed [32:0]  op_b;
    logic                pos;
    logic [3:0]          res_idx;
    logic [3:0]          out_idx;
    logic signed [66:0]  comp_raw;
    logic signed [66:0]  comp_val;
    logic [63:0]         trial;
    logic [32:0]         dtry;
    logic                dge;
    logic [31:0]         q32;
    logic [15:0]         qmag;
    logic                out_free;

    assign pos      = !res_reg[0][66] && (res_reg[0] != '0);
    assign res_idx  = 4'({2'b00, v_reg} * 4'd3) + 4'({2'b00, c_reg}) + 4'd1;
    assign out_idx  = 4'({2'b00, v_reg} * 4'd3) + 4'({2'b00, c_reg});
    assign comp_raw = res_reg[res_idx];
    assign comp_val = ((v_reg != 2'd0) && !pos) ? -comp_raw : comp_raw;
    assign trial    = root_reg + bit_reg;
    assign dtry     = {rem_reg, num_reg[NUMW-1]};
    assign dge      = dtry >= {1'b0, root_reg[31:0]};
    assign q32      = 32'(q_reg);
    assign qmag     = (q32 > 32'd32767) ? 16'd32767 : q32[15:0];
    assign out_free = !out_valid_reg || !frame_stall;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;

    assign frame_valid = out_valid_reg;
    assign frame       = out_reg;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (state_reg == S_MUL)
        begin
            case (k_reg)
                5'd0:  begin op_a = tri_reg.d1u; op_b = tri_reg.d2v; end
                5'd1:  begin op_a = tri_reg.d1v; op_b = tri_reg.d2u; end
                5'd2:  begin op_a = tri_reg.e1y; op_b = tri_reg.e2z; end
                5'd3:  begin op_a = tri_reg.e1z; op_b = tri_reg.e2y; end
                5'd4:  begin op_a = tri_reg.e1z; op_b = tri_reg.e2x; end
                5'd5:  begin op_a = tri_reg.e1x; op_b = tri_reg.e2z; end
                5'd6:  begin op_a = tri_reg.e1x; op_b = tri_reg.e2y; end
                5'd7:  begin op_a = tri_reg.e1y; op_b = tri_reg.e2x; end
                5'd8:  begin op_a = tri_reg.d2v; op_b = tri_reg.e1x; end
                5'd9:  begin op_a = tri_reg.d1v; op_b = tri_reg.e2x; end
                5'd10: begin op_a = tri_reg.d2v; op_b = tri_reg.e1y; end
                5'd11: begin op_a = tri_reg.d1v; op_b = tri_reg.e2y; end
                5'd12: begin op_a = tri_reg.d2v; op_b = tri_reg.e1z; end
                5'd13: begin op_a = tri_reg.d1v; op_b = tri_reg.e2z; end
                5'd14: begin op_a = tri_reg.d1u; op_b = tri_reg.e2x; end
                5'd15: begin op_a = tri_reg.d2u; op_b = tri_reg.e1x; end
                5'd16: begin op_a = tri_reg.d1u; op_b = tri_reg.e2y; end
                5'd17: begin op_a = tri_reg.d2u; op_b = tri_reg.e1y; end
                5'd18: begin op_a = tri_reg.d1u; op_b = tri_reg.e2z; end
                5'd19: begin op_a = tri_reg.d2u; op_b = tri_reg.e1z; end
                default: begin op_a = '0; op_b = '0; end
            endcase
        end
        else if (state_reg == S_SQM)
        begin
            op_a = {1'b0, mag_reg[c_reg][31:0]};
            op_b = {1'b0, mag_reg[c_reg][31:0]};
        end
        else if (state_reg == S_RSM)
        begin
            op_a = {2'b00, mag_reg[c_reg][30:0]};
            op_b = {2'b00, mag_reg[c_reg][30:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            min_len_sq_reg <= ttf_pkg::MIN_LEN_SQ_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_len_sq_reg <= cfg_wdata;
            end
            if (out_valid_reg && !frame_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:    state_reg <= S_ACC;
                S_ACC:    state_reg <= (k_reg == 5'd19) ? S_VINIT : S_MUL;
                S_VINIT:  state_reg <= S_LOAD;
                S_LOAD:   state_reg <= (c_reg == 2'd2) ? S_CLASS : S_LOAD;
                S_CLASS:
                begin
                    if (or_reg == '0)
                    begin
                        state_reg <= S_WRITE;
                    end
                    else if (or_reg[65:32] != '0)
                    begin
                        state_reg <= S_NORM;
                    end
                    else
                    begin
                        state_reg <= S_SQM;
                    end
                end
                S_SQM:    state_reg <= S_SQA;
                S_SQA:    state_reg <= (c_reg == 2'd2) ? S_SQC : S_SQM;
                S_SQC:    state_reg <= (sq_reg <= {3'b000, min_len_sq_reg}) ? S_WRITE : S_NORM;
                S_NORM:
                begin
                    if ((or_reg[65:31] == '0) && or_reg[30])
                    begin
                        state_reg <= S_RSM;
                    end
                end
                S_RSM:    state_reg <= S_RSA;
                S_RSA:    state_reg <= (c_reg == 2'd2) ? S_SQI : S_RSM;
                S_SQI:    state_reg <= S_SQRT;
                S_SQRT:   state_reg <= (it_reg == 5'd31) ? S_DLOAD : S_SQRT;
                S_DLOAD:  state_reg <= S_DIV;
                S_DIV:    state_reg <= (dcnt_reg == DCW'(NUMW - 1)) ? S_DSTORE : S_DIV;
                S_DSTORE: state_reg <= (c_reg == 2'd2) ? S_WRITE : S_DLOAD;
                S_WRITE:  state_reg <= (v_reg == 2'd2) ? S_OUT : S_VINIT;
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= op_a * op_b;
        case (state_reg)
            S_IDLE:
            begin
                tri_reg <= q_data;
                k_reg   <= 5'd0;
                v_reg   <= 2'd0;
            end
            S_ACC:
            begin
                if (!k_reg[0])
                begin
                    acc_reg <= {p_reg[65], p_reg};
                end
                else
                begin
                    res_reg[k_reg[4:1]] <= acc_reg - {p_reg[65], p_reg};
                end
                k_reg <= k_reg + 5'd1;
            end
            S_VINIT:
            begin
                c_reg   <= 2'd0;
                or_reg  <= '0;
                sq_reg  <= '0;
                l2_reg  <= '0;
                deg_reg <= 1'b0;
            end
            S_LOAD:
            begin
                neg_reg[c_reg] <= comp_val[66];
                mag_reg[c_reg] <= comp_val[66] ? 66'(-comp_val) : comp_val[65:0];
                or_reg <= or_reg | (comp_val[66] ? 66'(-comp_val) : comp_val[65:0]);
                c_reg  <= (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
            end
            S_CLASS:
            begin
                deg_reg <= (or_reg == '0);
            end
            S_SQA:
            begin
                sq_reg <= sq_reg + 66'(p_reg[63:0]);
                c_reg  <= (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
            end
            S_SQC:
            begin
                deg_reg <= (sq_reg <= {3'b000, min_len_sq_reg});
            end
            S_NORM:
            begin
                if (or_reg[65:31] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    or_reg <= or_reg >> 1;
                end
                else if (!or_reg[30])
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                    or_reg <= or_reg << 1;
                end
            end
            S_RSA:
            begin
                l2_reg <= l2_reg + p_reg[63:0];
                c_reg  <= (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
            end
            S_SQI:
            begin
                x_reg    <= l2_reg;
                root_reg <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
                it_reg   <= 5'd0;
            end
            S_SQRT:
            begin
                if (x_reg >= trial)
                begin
                    x_reg    <= x_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                it_reg  <= it_reg + 5'd1;
            end
            S_DLOAD:
            begin
                num_reg  <= (NUMW'(mag_reg[c_reg][30:0]) << OUT_FRAC_BITS)
                            + NUMW'(root_reg[31:1]);
                rem_reg  <= '0;
                q_reg    <= '0;
                dcnt_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg  <= dge ? 32'(dtry - {1'b0, root_reg[31:0]}) : dtry[31:0];
                q_reg    <= {q_reg[QW-2:0], dge};
                num_reg  <= num_reg << 1;
                dcnt_reg <= dcnt_reg + DCW'(1);
            end
            S_DSTORE:
            begin
                comp_reg[out_idx] <= neg_reg[c_reg] ? 16'd0 - qmag : qmag;
                c_reg <= (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
            end
            S_WRITE:
            begin
                fb_reg[v_reg] <= deg_reg;
                if (deg_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        comp_reg[4'({2'b00, v_reg} * 4'd3) + 4'(i)] <=
                            (((v_reg == 2'd0) && (i == 2)) ||
                             ((v_reg == 2'd1) && (i == 0)) ||
                             ((v_reg == 2'd2) && (i == 1))) ? ONE : 16'd0;
                    end
                end
                v_reg <= v_reg + 2'd1;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_reg.normal_x           <= comp_reg[0];
                    out_reg.normal_y           <= comp_reg[1];
                    out_reg.normal_z           <= comp_reg[2];
                    out_reg.tangent_x          <= comp_reg[3];
                    out_reg.tangent_y          <= comp_reg[4];
                    out_reg.tangent_z          <= comp_reg[5];
                    out_reg.binormal_x         <= comp_reg[6];
                    out_reg.binormal_y         <= comp_reg[7];
                    out_reg.binormal_z         <= comp_reg[8];
                    out_reg.normal_fell_back   <= fb_reg[0];
                    out_reg.tangent_fell_back  <= fb_reg[1];
                    out_reg.binormal_fell_back <= fb_reg[2];
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

### design/triangle_tangent_frame.sv
// channel   | valid         | stall         | payload
// corner in | corner_valid  | corner_stall  | corner (ttf_pkg::corner_t)
// frame out | frame_valid   | frame_stall   | frame  (ttf_pkg::frame_t)
// config    | cfg_we        | -             | cfg_wdata (min squared length)
// First and second corners are taken without a stall and give no item.
// The third corner is queued (two triangles deep); the back end takes one
// triangle at a time and forms its products, then per vector does set-up,
// length check and shift, 32 square root steps and a division for each
// component; a vector that falls back skips the root and the divisions.
// Reset clears the corner count, queue, sequencer and output valid; the
// register returns to 1. frame_stall holds the finished item in place.
module triangle_tangent_frame #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              corner_valid,
    output logic              corner_stall,
    input  ttf_pkg::corner_t  corner,
    output logic              frame_valid,
    input  logic              frame_stall,
    output ttf_pkg::frame_t   frame,
    input  logic              cfg_we,
    input  logic [62:0]       cfg_wdata
);

    ttf_pkg::q_ctl_t q_ctl;
    ttf_pkg::tri_t   tri_in;
    ttf_pkg::tri_t   tri_out;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;

    ttf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .corner_valid (corner_valid),
        .corner_stall (corner_stall),
        .corner       (corner),
        .q_full       (q_full),
        .q_ctl        (q_ctl),
        .tri_data     (tri_in)
    );

    ttf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_data (tri_in),
        .push    (q_ctl.push && !q_ctl.full),
        .pop     (q_pop),
        .rd_data (tri_out),
        .full    (q_full),
        .empty   (q_empty)
    );

    ttf_back #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_data      (tri_out),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame)
    );

endmodule

### tb/tb_triangle_tangent_frame.sv
module tb_triangle_tangent_frame;

    localparam int FRAC = 14;
    localparam int SETTLE = 700;

    logic clk;
    logic rst_n;
    logic corner_valid;
    logic corner_stall;
    ttf_pkg::corner_t corner;
    logic frame_valid;
    logic frame_stall;
    ttf_pkg::frame_t frame;
    logic cfg_we;
    logic [62:0] cfg_wdata;

    triangle_tangent_frame #(.OUT_FRAC_BITS(FRAC)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .corner_valid(corner_valid),
        .corner_stall(corner_stall),
        .corner(corner),
        .frame_valid(frame_valid),
        .frame_stall(frame_stall),
        .frame(frame),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    ttf_pkg::corner_t pending_corners[$];
    ttf_pkg::frame_t expected_frames[$];
    ttf_pkg::corner_t held[2];
    int held_count = 0;
    logic [62:0] min_len_sq = ttf_pkg::MIN_LEN_SQ_RESET;
    bit failed = 0;
    logic corner_taken = 0;
    logic frame_taken = 0;
    int gap_left = 0;
    int corners_sent = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 0;
    int frames_seen = 0;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic signed [127:0] wide_mul(input longint a, input longint b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // normalise one vector to Q1.FRAC or fall back to the given axis
    task automatic unit_vector(input logic signed [127:0] v[3], input int axis,
                               output logic signed [15:0] o[3], output logic flag);
        logic [127:0] mag[3];
        logic [127:0] all_bits;
        logic [65:0] sq_sum;
        logic [63:0] r[3];
        logic [63:0] l2;
        logic [63:0] len;
        logic [63:0] q;
        int n;
        bit degen;
        all_bits = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            all_bits = all_bits | mag[i];
        end
        n = 0;
        for (int i = 0; i < 128; i++)
            if (all_bits[i])
                n = i + 1;
        if (n == 0)
            degen = 1;
        else if (n > 32)
            degen = 0;
        else
        begin
            sq_sum = 0;
            for (int i = 0; i < 3; i++)
                sq_sum = sq_sum + mag[i][63:0] * mag[i][63:0];
            degen = sq_sum <= {3'b0, min_len_sq};
        end
        if (degen)
        begin
            for (int i = 0; i < 3; i++)
                o[i] = (i == axis) ? ((1 << FRAC) > 32767 ? 32767 : (1 << FRAC)) : 0;
            flag = 1;
            return;
        end
        l2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (n > 31)
                r[i] = mag[i] >> (n - 31);
            else
                r[i] = mag[i] << (31 - n);
            l2 = l2 + r[i] * r[i];
        end
        len = int_sqrt(l2);
        for (int i = 0; i < 3; i++)
        begin
            q = len != 0 ? ((r[i] << FRAC) + len / 2) / len : 0;
            if (q > 32767)
                q = 32767;
            o[i] = v[i] < 0 ? -q[15:0] : q[15:0];
        end
        flag = 0;
    endtask

    task automatic predict_frame(input ttf_pkg::corner_t c0, input ttf_pkg::corner_t c1,
                                 input ttf_pkg::corner_t c2, output ttf_pkg::frame_t f);
        longint e1[3];
        longint e2[3];
        longint d1u, d1v, d2u, d2v;
        logic signed [127:0] det;
        logic signed [127:0] nv[3];
        logic signed [127:0] tv[3];
        logic signed [127:0] bv[3];
        logic signed [15:0] o[3];
        logic flag;
        e1[0] = longint'(c1.pos_x) - longint'(c0.pos_x);
        e1[1] = longint'(c1.pos_y) - longint'(c0.pos_y);
        e1[2] = longint'(c1.pos_z) - longint'(c0.pos_z);
        e2[0] = longint'(c2.pos_x) - longint'(c0.pos_x);
        e2[1] = longint'(c2.pos_y) - longint'(c0.pos_y);
        e2[2] = longint'(c2.pos_z) - longint'(c0.pos_z);
        d1u = longint'(c1.tex_u) - longint'(c0.tex_u);
        d1v = longint'(c1.tex_v) - longint'(c0.tex_v);
        d2u = longint'(c2.tex_u) - longint'(c0.tex_u);
        d2v = longint'(c2.tex_v) - longint'(c0.tex_v);
        det = wide_mul(d1u, d2v) - wide_mul(d1v, d2u);
        nv[0] = wide_mul(e1[1], e2[2]) - wide_mul(e1[2], e2[1]);
        nv[1] = wide_mul(e1[2], e2[0]) - wide_mul(e1[0], e2[2]);
        nv[2] = wide_mul(e1[0], e2[1]) - wide_mul(e1[1], e2[0]);
        for (int i = 0; i < 3; i++)
        begin
            tv[i] = wide_mul(d2v, e1[i]) - wide_mul(d1v, e2[i]);
            bv[i] = wide_mul(d1u, e2[i]) - wide_mul(d2u, e1[i]);
            if (!(det > 0))
            begin
                tv[i] = -tv[i];
                bv[i] = -bv[i];
            end
        end
        unit_vector(nv, 2, o, flag);
        f.normal_x = o[0];
        f.normal_y = o[1];
        f.normal_z = o[2];
        f.normal_fell_back = flag;
        unit_vector(tv, 0, o, flag);
        f.tangent_x = o[0];
        f.tangent_y = o[1];
        f.tangent_z = o[2];
        f.tangent_fell_back = flag;
        unit_vector(bv, 1, o, flag);
        f.binormal_x = o[0];
        f.binormal_y = o[1];
        f.binormal_z = o[2];
        f.binormal_fell_back = flag;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1;
        end
    endtask

    function automatic logic [31:0] jitter(input int bits);
        logic [31:0] d;
        if (bits >= 32)
            return $urandom;
        d = $urandom_range(0, (1 << bits) - 1);
        return $urandom_range(0, 1) ? d : -d;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return jitter($urandom_range(0, 20));
            default: return $urandom;
        endcase
    endfunction

    function automatic ttf_pkg::corner_t offset_corner(input ttf_pkg::corner_t b,
                                                       input int bits);
        ttf_pkg::corner_t c;
        c.pos_x = b.pos_x + jitter(bits);
        c.pos_y = b.pos_y + jitter(bits);
        c.pos_z = b.pos_z + jitter(bits);
        c.tex_u = b.tex_u + jitter(bits);
        c.tex_v = b.tex_v + jitter(bits);
        return c;
    endfunction

    task automatic queue_triangle(input ttf_pkg::corner_t a, input ttf_pkg::corner_t b,
                                  input ttf_pkg::corner_t c);
        pending_corners.push_back(a);
        pending_corners.push_back(b);
        pending_corners.push_back(c);
    endtask

    task automatic queue_random_triangles(input int count);
        ttf_pkg::corner_t a, b, c;
        int bits;
        for (int t = 0; t < count; t++)
        begin
            a = {pick_value(), pick_value(), pick_value(), pick_value(), pick_value()};
            bits = $urandom_range(0, 3) == 0 ? 32 : $urandom_range(0, 31);
            b = offset_corner(a, bits);
            c = offset_corner(a, bits);
            case ($urandom_range(0, 9))
                0: c = a;
                1:
                begin
                    c.pos_x = a.pos_x + 2 * (b.pos_x - a.pos_x);
                    c.pos_y = a.pos_y + 2 * (b.pos_y - a.pos_y);
                    c.pos_z = a.pos_z + 2 * (b.pos_z - a.pos_z);
                end
                2:
                begin
                    c.tex_u = a.tex_u;
                    c.tex_v = a.tex_v;
                end
                default: ;
            endcase
            queue_triangle(a, b, c);
        end
    endtask

    task automatic queue_directed();
        ttf_pkg::corner_t z, lo, hi, a, b, c;
        z = '0;
        lo = {5{32'h8000_0000}};
        hi = {5{32'h7FFF_FFFF}};
        queue_triangle(z, z, z);
        queue_triangle(lo, hi, z);
        queue_triangle(hi, lo, {32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000});
        a = '0;
        b = '0;
        c = '0;
        b.pos_x = 32'h0001_0000;
        b.tex_u = 32'h0100_0000;
        c.pos_y = 32'h0001_0000;
        c.tex_v = 32'h0100_0000;
        queue_triangle(a, b, c);
        queue_triangle(a, c, b);
        b.pos_x = 32'd1;
        c.pos_y = 32'd1;
        queue_triangle(a, b, c);
        b.pos_x = 32'h0002_0000;
        c = b;
        queue_triangle(a, b, c);
    endtask

    task automatic write_threshold(input logic [62:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        min_len_sq = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_corners.size() != 0 || corner_valid || expected_frames.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        logic [62:0] thresholds[6];
        rst_n = 1'b0;
        corner_valid = 1'b0;
        corner = '0;
        frame_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        thresholds[0] = 63'd0;
        thresholds[1] = 63'h7FFF_FFFF_FFFF_FFFF;
        thresholds[2] = 63'd1 << 20;
        thresholds[3] = 63'd1 << 45;
        thresholds[4] = {$urandom, $urandom};
        thresholds[5] = 63'd1;
        queue_directed();
        queue_random_triangles(20);
        drain();
        for (int p = 0; p < 6; p++)
        begin
            write_threshold(thresholds[p]);
            queue_random_triangles(60);
            drain();
        end
        if (!failed)
            $display("triangle_tangent_frame test passed");
        else
            $display("triangle_tangent_frame test failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("triangle_tangent_frame test failed");
        $finish;
    end

    always @(posedge clk)
    begin
        ttf_pkg::frame_t f;
        corner_taken <= corner_valid && !corner_stall;
        frame_taken <= frame_valid && !frame_stall;
        if (corner_valid && !corner_stall)
        begin
            if (held_count < 2)
            begin
                held[held_count] = corner;
                held_count++;
            end
            else
            begin
                predict_frame(held[0], held[1], corner, f);
                expected_frames.push_back(f);
                held_count = 0;
            end
        end
        if (frame_valid && !frame_stall)
        begin
            frames_seen++;
            if (expected_frames.size() == 0)
            begin
                $error("item with none expected");
                failed = 1;
            end
            else
            begin
                f = expected_frames.pop_front();
                check_field("normal_x", f.normal_x, frame.normal_x);
                check_field("normal_y", f.normal_y, frame.normal_y);
                check_field("normal_z", f.normal_z, frame.normal_z);
                check_field("tangent_x", f.tangent_x, frame.tangent_x);
                check_field("tangent_y", f.tangent_y, frame.tangent_y);
                check_field("tangent_z", f.tangent_z, frame.tangent_z);
                check_field("binormal_x", f.binormal_x, frame.binormal_x);
                check_field("binormal_y", f.binormal_y, frame.binormal_y);
                check_field("binormal_z", f.binormal_z, frame.binormal_z);
                check_field("normal_fell_back", f.normal_fell_back, frame.normal_fell_back);
                check_field("tangent_fell_back", f.tangent_fell_back,
                            frame.tangent_fell_back);
                check_field("binormal_fell_back", f.binormal_fell_back,
                            frame.binormal_fell_back);
            end
        end
    end

    // corner driver
    always @(negedge clk)
    begin
        if (rst_n && (corner_taken || !corner_valid))
        begin
            if (corner_taken)
            begin
                corners_sent++;
                gap_left = ((corners_sent / 90) % 3 == 0) ? 0 : $urandom_range(0, 8);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                corner_valid <= 1'b0;
            end
            else if (pending_corners.size() != 0)
            begin
                corner <= pending_corners.pop_front();
                corner_valid <= 1'b1;
            end
            else
                corner_valid <= 1'b0;
        end
    end

    // frame receiver, with one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (frames_seen == 30 && !hold_done)
            begin
                hold_done = 1;
                hold_left = 4000;
            end
            if (frame_taken)
                stall_left = ((frames_seen / 40) % 3 == 0) ? 0 : $urandom_range(0, 8);
            if (hold_left > 0)
            begin
                hold_left--;
                frame_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                frame_stall <= 1'b1;
            end
            else
                frame_stall <= 1'b0;
        end
    end

endmodule

### triangle_tangent_frame.f
design/ttf_pkg.sv
design/ttf_queue.sv
design/ttf_front.sv
design/ttf_back.sv
design/triangle_tangent_frame.sv
tb/tb_triangle_tangent_frame.sv
